[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rv32im decoder checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/rvid_pkg.sv]
// ----------------------------------------------------------------------------
// rvid_pkg
// types, codes and lookup functions for the rv32im instruction decoder
// ----------------------------------------------------------------------------
package rvid_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned IdWidth    = 6;
  localparam int unsigned FmtWidth   = 3;
  localparam int unsigned RegWidth   = 5;
  localparam int unsigned OutWidth   = 64;

  typedef logic [IdWidth-1:0]  instr_id_t;
  typedef logic [FmtWidth-1:0] fmt_t;
  typedef logic [RegWidth-1:0] reg_idx_t;

  // instruction identifiers
  localparam instr_id_t ID_LW    = 6'd0;
  localparam instr_id_t ID_LH    = 6'd1;
  localparam instr_id_t ID_LHU   = 6'd2;
  localparam instr_id_t ID_LBU   = 6'd3;
  localparam instr_id_t ID_SW    = 6'd4;
  localparam instr_id_t ID_SH    = 6'd5;
  localparam instr_id_t ID_SB    = 6'd6;
  localparam instr_id_t ID_LUI   = 6'd7;
  localparam instr_id_t ID_ADDI  = 6'd8;
  localparam instr_id_t ID_SLTIU = 6'd9;
  localparam instr_id_t ID_ANDI  = 6'd10;
  localparam instr_id_t ID_XORI  = 6'd11;
  localparam instr_id_t ID_SRAI  = 6'd12;
  localparam instr_id_t ID_SRLI  = 6'd13;
  localparam instr_id_t ID_SLLI  = 6'd14;
  localparam instr_id_t ID_AUIPC = 6'd15;
  localparam instr_id_t ID_JAL   = 6'd16;
  localparam instr_id_t ID_JALR  = 6'd17;
  localparam instr_id_t ID_ADD   = 6'd18;
  localparam instr_id_t ID_SUB   = 6'd19;
  localparam instr_id_t ID_SRA   = 6'd20;
  localparam instr_id_t ID_SRL   = 6'd21;
  localparam instr_id_t ID_SLTU  = 6'd22;
  localparam instr_id_t ID_XOR   = 6'd23;
  localparam instr_id_t ID_OR    = 6'd24;
  localparam instr_id_t ID_SLL   = 6'd25;
  localparam instr_id_t ID_SLT   = 6'd26;
  localparam instr_id_t ID_AND   = 6'd27;
  localparam instr_id_t ID_MUL   = 6'd28;
  localparam instr_id_t ID_MULH  = 6'd29;
  localparam instr_id_t ID_DIV   = 6'd30;
  localparam instr_id_t ID_DIVU  = 6'd31;
  localparam instr_id_t ID_REM   = 6'd32;
  localparam instr_id_t ID_REMU  = 6'd33;
  localparam instr_id_t ID_BEQ   = 6'd34;
  localparam instr_id_t ID_BNE   = 6'd35;
  localparam instr_id_t ID_BGE   = 6'd36;
  localparam instr_id_t ID_BLT   = 6'd37;
  localparam instr_id_t ID_BLTU  = 6'd38;
  localparam instr_id_t ID_BGEU  = 6'd39;
  localparam instr_id_t ID_TRAP  = 6'd40;
  localparam instr_id_t ID_INV   = 6'd41;

  // format classes
  localparam fmt_t FMT_I    = 3'd0;
  localparam fmt_t FMT_S    = 3'd1;
  localparam fmt_t FMT_U    = 3'd2;
  localparam fmt_t FMT_J    = 3'd3;
  localparam fmt_t FMT_R    = 3'd4;
  localparam fmt_t FMT_B    = 3'd5;
  localparam fmt_t FMT_NONE = 3'd6;

  // major opcodes, bits 6:2
  localparam logic [4:0] OP_LOAD   = 5'h00;
  localparam logic [4:0] OP_IMM    = 5'h04;
  localparam logic [4:0] OP_AUIPC  = 5'h05;
  localparam logic [4:0] OP_STORE  = 5'h08;
  localparam logic [4:0] OP_REG    = 5'h0c;
  localparam logic [4:0] OP_LUI    = 5'h0d;
  localparam logic [4:0] OP_BRANCH = 5'h18;
  localparam logic [4:0] OP_JALR   = 5'h19;
  localparam logic [4:0] OP_TRAP   = 5'h1a;
  localparam logic [4:0] OP_JAL    = 5'h1b;

  localparam logic [1:0] OP_LOW    = 2'b11;
  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  typedef struct packed {
    logic [31:0] immediate;
    logic        rd_write_enable;
    reg_idx_t    rd_index;
    reg_idx_t    rs2_index;
    reg_idx_t    rs1_index;
    fmt_t        format_class;
    instr_id_t   instr_id;
  } rvid_dec_t;

  function automatic instr_id_t load_id(input logic [2:0] f3);
    case (f3)
      3'd1:    load_id = ID_LH;
      3'd2:    load_id = ID_LW;
      3'd4:    load_id = ID_LBU;
      3'd5:    load_id = ID_LHU;
      default: load_id = ID_INV;
    endcase
  endfunction

  function automatic instr_id_t store_id(input logic [2:0] f3);
    case (f3)
      3'd0:    store_id = ID_SB;
      3'd1:    store_id = ID_SH;
      3'd2:    store_id = ID_SW;
      default: store_id = ID_INV;
    endcase
  endfunction

  function automatic instr_id_t branch_id(input logic [2:0] f3);
    case (f3)
      3'd0:    branch_id = ID_BEQ;
      3'd1:    branch_id = ID_BNE;
      3'd4:    branch_id = ID_BLT;
      3'd5:    branch_id = ID_BGE;
      3'd6:    branch_id = ID_BLTU;
      3'd7:    branch_id = ID_BGEU;
      default: branch_id = ID_INV;
    endcase
  endfunction

  function automatic instr_id_t imm_op_id(input logic [2:0] f3, input logic [6:0] f7);
    case (f3)
      3'd0:    imm_op_id = ID_ADDI;
      3'd3:    imm_op_id = ID_SLTIU;
      3'd7:    imm_op_id = ID_ANDI;
      3'd4:    imm_op_id = ID_XORI;
      3'd5:    imm_op_id = (f7 == F7_ALT) ? ID_SRAI : ((f7 == F7_BASE) ? ID_SRLI : ID_INV);
      3'd1:    imm_op_id = (f7 == F7_BASE) ? ID_SLLI : ID_INV;
      default: imm_op_id = ID_INV;
    endcase
  endfunction

  function automatic instr_id_t reg_op_id(input logic [2:0] f3, input logic [6:0] f7);
    reg_op_id = ID_INV;
    if (f7 == F7_MULDIV) begin
      case (f3)
        3'd0:    reg_op_id = ID_MUL;
        3'd1:    reg_op_id = ID_MULH;
        3'd4:    reg_op_id = ID_DIV;
        3'd5:    reg_op_id = ID_DIVU;
        3'd6:    reg_op_id = ID_REM;
        3'd7:    reg_op_id = ID_REMU;
        default: reg_op_id = ID_INV;
      endcase
    end else if (f7 == F7_BASE) begin
      case (f3)
        3'd0:    reg_op_id = ID_ADD;
        3'd1:    reg_op_id = ID_SLL;
        3'd2:    reg_op_id = ID_SLT;
        3'd3:    reg_op_id = ID_SLTU;
        3'd4:    reg_op_id = ID_XOR;
        3'd5:    reg_op_id = ID_SRL;
        3'd6:    reg_op_id = ID_OR;
        default: reg_op_id = ID_AND;
      endcase
    end else if (f7 == F7_ALT) begin
      if (f3 == 3'd0) begin
        reg_op_id = ID_SUB;
      end else if (f3 == 3'd5) begin
        reg_op_id = ID_SRA;
      end
    end
  endfunction

endpackage

[src/rvid_decode.sv]
// ----------------------------------------------------------------------------
// rvid_decode
// combinational decode of one rv32im instruction word
// ----------------------------------------------------------------------------
module rvid_decode (
  input  logic [rvid_pkg::InstrWidth-1:0] instr,
  output rvid_pkg::rvid_dec_t             dec
);
  import rvid_pkg::*;

  logic [2:0] f3;
  logic [6:0] f7;
  instr_id_t  id;
  fmt_t       fmt;

  assign f3 = instr[14:12];
  assign f7 = instr[31:25];

  always_comb begin
    id  = ID_INV;
    fmt = FMT_NONE;
    if (instr[1:0] == OP_LOW) begin
      case (instr[6:2])
        OP_LOAD:   begin id = load_id(f3);       fmt = FMT_I;    end
        OP_STORE:  begin id = store_id(f3);      fmt = FMT_S;    end
        OP_LUI:    begin id = ID_LUI;            fmt = FMT_U;    end
        OP_IMM:    begin id = imm_op_id(f3, f7); fmt = FMT_I;    end
        OP_AUIPC:  begin id = ID_AUIPC;          fmt = FMT_U;    end
        OP_JAL:    begin id = ID_JAL;            fmt = FMT_J;    end
        OP_JALR:   begin id = ID_JALR;           fmt = FMT_I;    end
        OP_REG:    begin id = reg_op_id(f3, f7); fmt = FMT_R;    end
        OP_BRANCH: begin id = branch_id(f3);     fmt = FMT_B;    end
        OP_TRAP:   begin id = ID_TRAP;           fmt = FMT_NONE; end
        default:   begin id = ID_INV;            fmt = FMT_NONE; end
      endcase
    end
    if (id == ID_INV) begin
      fmt = FMT_NONE;
    end
  end

  always_comb begin
    dec              = '0;
    dec.instr_id     = id;
    dec.format_class = fmt;
    case (fmt)
      FMT_I: begin
        dec.rs1_index = instr[19:15];
        dec.rd_index  = instr[11:7];
        dec.immediate = {{20{instr[31]}}, instr[31:20]};
      end
      FMT_S: begin
        dec.rs1_index = instr[19:15];
        dec.rs2_index = instr[24:20];
        dec.immediate = {{20{instr[31]}}, instr[31:25], instr[11:7]};
      end
      FMT_U: begin
        dec.rd_index  = instr[11:7];
        dec.immediate = {instr[31:12], 12'b0};
      end
      FMT_J: begin
        dec.rd_index  = instr[11:7];
        dec.immediate = {{11{instr[31]}}, instr[31], instr[19:12], instr[20],
                         instr[30:21], 1'b0};
      end
      FMT_R: begin
        dec.rs1_index = instr[19:15];
        dec.rs2_index = instr[24:20];
        dec.rd_index  = instr[11:7];
      end
      FMT_B: begin
        dec.rs1_index = instr[19:15];
        dec.rs2_index = instr[24:20];
        dec.immediate = {{19{instr[31]}}, instr[31], instr[7], instr[30:25],
                         instr[11:8], 1'b0};
      end
      default: begin
        dec.immediate = '0;
      end
    endcase
    dec.rd_write_enable = (fmt inside {FMT_I, FMT_U, FMT_J, FMT_R}) &&
                          (dec.rd_index != '0);
  end

endmodule

[src/rv32im_instruction_decoder_top.sv]
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_top
// streaming rv32im instruction decoder with registered input and result
// ----------------------------------------------------------------------------
// Decodes one 32-bit RV32IM instruction per transfer into an instruction id,
// format class, register indices, destination write enable and sign-extended
// immediate. A new instruction is taken every cycle unless out_tready stalls
// the output; each result passes the input register, then the result register,
// and decode of the registered word fits in the single stage between them.
// Unknown or unsupported words come out as invalid, format none, other fields zero.
module rv32im_instruction_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [31:0] instruction_word
  input  logic [rvid_pkg::InstrWidth-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [5:0] instr_id, [8:6] format_class, [13:9] rs1_index, [18:14] rs2_index,
  // [23:19] rd_index, [24] rd_write_enable, [56:25] immediate, [63:57] zero
  output logic [rvid_pkg::OutWidth-1:0]   out_tdata
);
  import rvid_pkg::*;

  logic [InstrWidth-1:0] instr_r;
  logic                  in_vld_r;
  rvid_dec_t             dec;
  rvid_dec_t             res_r;
  logic                  out_vld_r;
  logic                  res_load;
  logic                  in_load;
  logic                  in_vld_nxt;
  logic                  out_vld_nxt;

  rvid_decode u_decode (
    .instr (instr_r),
    .dec   (dec)
  );

  assign res_load    = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready   = !in_vld_r || res_load;
  assign in_load     = in_tvalid && in_tready;
  assign in_vld_nxt  = in_load || (in_vld_r && !res_load);
  assign out_vld_nxt = res_load || (out_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      instr_r <= in_tdata;
    end
    if (res_load) begin
      res_r <= dec;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutWidth - $bits(rvid_dec_t)){1'b0}}, res_r};

endmodule

[src/rvid_checker.sv]
// ----------------------------------------------------------------------------
// rvid_checker
// port-level assertions for the rv32im decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rvid_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rvid_pkg::OutWidth-1:0]   out_tdata
);
  import rvid_pkg::*;

  logic in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  // stalled result holds its value
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata))

  // invalid and trap results carry format none and no other fields
  `ASSERT_IMPL(a_none_zero, clk, rst_n,
               out_tvalid && (out_tdata[5:0] == ID_INV || out_tdata[5:0] == ID_TRAP),
               out_tdata[8:6] == FMT_NONE && out_tdata[63:9] == '0)

  // write enable never targets x0
  `ASSERT_IMPL(a_we_rd, clk, rst_n, out_tvalid && out_tdata[24], out_tdata[23:19] != '0)

  // register format has no immediate
  `ASSERT_IMPL(a_r_imm, clk, rst_n, out_tvalid && out_tdata[8:6] == FMT_R, out_tdata[56:25] == '0)

  // an input transfer with an idle output leads to a valid result after the input and result registers
  `ASSERT_NEXT(a_latency, clk, rst_n, in_xfer && !out_tvalid, ##1 out_tvalid)

endmodule

bind rv32im_instruction_decoder_top rvid_checker u_rvid_checker (.*);

[tb/rv32im_instruction_decoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_top_tb
// self-checking stream test of the rv32im instruction decoder
// ----------------------------------------------------------------------------
// Instruction words are sent one transfer at a time and decoded in parallel
// by a local model of the RV32IM subset; every result transfer is compared
// field by field against the oldest pending decode. Directed words cover
// immediate extremes, x0 destinations, trap and the unsupported encodings;
// random words are mostly well-formed opcodes with random fields, run under
// several sender and receiver idle mixes plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_top_tb;
  import rvid_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES = 8;

  // packed id maps indexed by funct3, entry 0 in the low bits
  localparam logic [47:0] LOAD_MAP =
    {ID_INV, ID_INV, ID_LHU, ID_LBU, ID_INV, ID_LW, ID_LH, ID_INV};
  localparam logic [47:0] STORE_MAP =
    {ID_INV, ID_INV, ID_INV, ID_INV, ID_INV, ID_SW, ID_SH, ID_SB};
  localparam logic [47:0] BRANCH_MAP =
    {ID_BGEU, ID_BLTU, ID_BGE, ID_BLT, ID_INV, ID_INV, ID_BNE, ID_BEQ};
  localparam logic [47:0] ALU_MAP =
    {ID_AND, ID_OR, ID_SRL, ID_XOR, ID_SLTU, ID_SLT, ID_SLL, ID_ADD};
  localparam logic [47:0] MULDIV_MAP =
    {ID_REMU, ID_REM, ID_DIVU, ID_DIV, ID_INV, ID_INV, ID_MULH, ID_MUL};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  rvid_dec_t   expected_decodes[$];
  logic [31:0] pending_words[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  rv32im_instruction_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] encode(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [4:0] op);
    return {f7, rs2, rs1, f3, rd, op, OP_LOW};
  endfunction

  function automatic rvid_dec_t decode_word(input logic [31:0] w);
    rvid_dec_t  d;
    logic [2:0] f3;
    logic [6:0] f7;
    f3 = w[14:12];
    f7 = w[31:25];
    d = '0;
    d.instr_id = ID_INV;
    d.format_class = FMT_NONE;
    if (w[1:0] == OP_LOW) begin
      case (w[6:2])
        OP_LOAD: begin
          d.instr_id = LOAD_MAP[f3*6 +: 6];
          d.format_class = FMT_I;
        end
        OP_STORE: begin
          d.instr_id = STORE_MAP[f3*6 +: 6];
          d.format_class = FMT_S;
        end
        OP_BRANCH: begin
          d.instr_id = BRANCH_MAP[f3*6 +: 6];
          d.format_class = FMT_B;
        end
        OP_LUI: begin
          d.instr_id = ID_LUI;
          d.format_class = FMT_U;
        end
        OP_AUIPC: begin
          d.instr_id = ID_AUIPC;
          d.format_class = FMT_U;
        end
        OP_JAL: begin
          d.instr_id = ID_JAL;
          d.format_class = FMT_J;
        end
        OP_JALR: begin
          d.instr_id = ID_JALR;
          d.format_class = FMT_I;
        end
        OP_TRAP: begin
          d.instr_id = ID_TRAP;
        end
        OP_IMM: begin
          d.format_class = FMT_I;
          if (f3 == 3'd0) d.instr_id = ID_ADDI;
          else if (f3 == 3'd3) d.instr_id = ID_SLTIU;
          else if (f3 == 3'd4) d.instr_id = ID_XORI;
          else if (f3 == 3'd7) d.instr_id = ID_ANDI;
          else if (f3 == 3'd1 && f7 == F7_BASE) d.instr_id = ID_SLLI;
          else if (f3 == 3'd5 && f7 == F7_BASE) d.instr_id = ID_SRLI;
          else if (f3 == 3'd5 && f7 == F7_ALT) d.instr_id = ID_SRAI;
        end
        OP_REG: begin
          d.format_class = FMT_R;
          if (f7 == F7_BASE) d.instr_id = ALU_MAP[f3*6 +: 6];
          else if (f7 == F7_MULDIV) d.instr_id = MULDIV_MAP[f3*6 +: 6];
          else if (f7 == F7_ALT && f3 == 3'd0) d.instr_id = ID_SUB;
          else if (f7 == F7_ALT && f3 == 3'd5) d.instr_id = ID_SRA;
        end
        default: ;
      endcase
    end
    if (d.instr_id == ID_INV) d.format_class = FMT_NONE;

    case (d.format_class)
      FMT_I: begin
        d.rs1_index = w[19:15];
        d.rd_index = w[11:7];
        d.immediate = {{20{w[31]}}, w[31:20]};
      end
      FMT_S: begin
        d.rs1_index = w[19:15];
        d.rs2_index = w[24:20];
        d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      FMT_U: begin
        d.rd_index = w[11:7];
        d.immediate = {w[31:12], 12'b0};
      end
      FMT_J: begin
        d.rd_index = w[11:7];
        d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      FMT_R: begin
        d.rs1_index = w[19:15];
        d.rs2_index = w[24:20];
        d.rd_index = w[11:7];
      end
      FMT_B: begin
        d.rs1_index = w[19:15];
        d.rs2_index = w[24:20];
        d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      default: ;
    endcase
    d.rd_write_enable = (d.format_class inside {FMT_I, FMT_U, FMT_J, FMT_R}) &&
                        (d.rd_index != '0);
    return d;
  endfunction

  // mostly well-formed words with random fields, the rest noise, some with the low opcode bits set
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          pick;
    w = $urandom();
    pick = $urandom_range(99);
    if (pick < 85) begin
      w[1:0] = OP_LOW;
      case ($urandom_range(9))
        0: w[6:2] = OP_LOAD;
        1: w[6:2] = OP_STORE;
        2: w[6:2] = OP_BRANCH;
        3: w[6:2] = OP_LUI;
        4: w[6:2] = OP_AUIPC;
        5: w[6:2] = OP_JAL;
        6: w[6:2] = OP_JALR;
        7: w[6:2] = OP_TRAP;
        8: w[6:2] = OP_IMM;
        default: w[6:2] = OP_REG;
      endcase
      if (w[6:2] == OP_IMM || w[6:2] == OP_REG) begin
        case ($urandom_range(4))
          0, 1: w[31:25] = F7_BASE;
          2: w[31:25] = F7_ALT;
          3: w[31:25] = F7_MULDIV;
          default: ;
        endcase
      end
    end else if (pick < 93) begin
      w[1:0] = OP_LOW;
    end
    return w;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    expected_decodes.push_back(decode_word(w));
    pending_words.push_back(w);
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic set_idling(input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    send_word(encode(7'h40, 5'd0, 5'd31, 3'd0, 5'd31, OP_IMM));
    send_word(encode(7'h7f, 5'd31, 5'd0, 3'd0, 5'd0, OP_IMM));
    send_word(encode(7'h00, 5'd3, 5'd4, 3'd6, 5'd5, OP_IMM));
    send_word(encode(7'h00, 5'd3, 5'd4, 3'd2, 5'd5, OP_IMM));
    send_word(encode(F7_ALT, 5'd7, 5'd1, 3'd1, 5'd2, OP_IMM));
    send_word(encode(F7_ALT, 5'd31, 5'd3, 3'd5, 5'd4, OP_IMM));
    send_word(encode(F7_MULDIV, 5'd1, 5'd3, 3'd5, 5'd4, OP_IMM));
    send_word(encode(F7_MULDIV, 5'd9, 5'd8, 3'd2, 5'd7, OP_REG));
    send_word(encode(F7_MULDIV, 5'd9, 5'd8, 3'd3, 5'd7, OP_REG));
    send_word(encode(F7_ALT, 5'd31, 5'd31, 3'd0, 5'd31, OP_REG));
    send_word(encode(F7_ALT, 5'd1, 5'd2, 3'd5, 5'd3, OP_REG));
    send_word(encode(F7_ALT, 5'd1, 5'd2, 3'd1, 5'd3, OP_REG));
    send_word(encode(F7_BASE, 5'd6, 5'd5, 3'd7, 5'd0, OP_REG));
    send_word(encode(7'h3f, 5'd31, 5'd1, 3'd2, 5'd2, OP_LOAD));
    send_word(encode(7'h00, 5'd0, 5'd1, 3'd3, 5'd2, OP_LOAD));
    send_word(encode(7'h40, 5'd5, 5'd6, 3'd2, 5'd0, OP_STORE));
    send_word(encode(7'h3f, 5'd5, 5'd6, 3'd0, 5'd31, OP_STORE));
    send_word(encode(7'h00, 5'd5, 5'd6, 3'd3, 5'd1, OP_STORE));
    send_word(encode(7'h7f, 5'd31, 5'd31, 3'd0, 5'd31, OP_BRANCH));
    send_word(encode(7'h3f, 5'd1, 5'd2, 3'd7, 5'd30, OP_BRANCH));
    send_word(encode(7'h00, 5'd1, 5'd2, 3'd2, 5'd3, OP_BRANCH));
    send_word(encode(7'h7f, 5'd31, 5'd31, 3'd7, 5'd0, OP_LUI));
    send_word(encode(7'h7f, 5'd31, 5'd31, 3'd7, 5'd31, OP_AUIPC));
    send_word(encode(7'h7f, 5'd31, 5'd31, 3'd7, 5'd31, OP_JAL));
    send_word(encode(7'h40, 5'd0, 5'd0, 3'd0, 5'd1, OP_JAL));
    send_word(encode(7'h00, 5'd1, 5'd2, 3'd7, 5'd3, OP_JALR));
    send_word(encode(7'h7f, 5'd31, 5'd31, 3'd7, 5'd31, OP_TRAP));
    send_word({25'h1ff_ffff, OP_TRAP, 2'b10});
  endtask

  task automatic test_random_phase(input int count, input int idle, input int stall);
    set_idling(idle, stall);
    repeat (count) send_word(random_word());
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_requests <= hold_requests + 1;
    repeat (48) send_word(random_word());
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_field(input string field, input logic [31:0] w,
                              input logic [31:0] want, input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s word=%08h expected=%0h actual=%0h", field, w, want, got);
  endtask

  always @(posedge clk) begin
    rvid_dec_t   want;
    rvid_dec_t   got;
    logic [31:0] w;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[56:0];
      if (expected_decodes.size() == 0) begin
        report_field("unexpected transfer", '0, '0, out_tdata[31:0]);
      end else begin
        want = expected_decodes.pop_front();
        w = pending_words.pop_front();
        if (got.instr_id != want.instr_id)
          report_field("instr_id", w, 32'(want.instr_id), 32'(got.instr_id));
        if (got.format_class != want.format_class)
          report_field("format_class", w, 32'(want.format_class), 32'(got.format_class));
        if (got.rs1_index != want.rs1_index)
          report_field("rs1_index", w, 32'(want.rs1_index), 32'(got.rs1_index));
        if (got.rs2_index != want.rs2_index)
          report_field("rs2_index", w, 32'(want.rs2_index), 32'(got.rs2_index));
        if (got.rd_index != want.rd_index)
          report_field("rd_index", w, 32'(want.rd_index), 32'(got.rd_index));
        if (got.rd_write_enable != want.rd_write_enable)
          report_field("rd_write_enable", w, 32'(want.rd_write_enable),
                       32'(got.rd_write_enable));
        if (got.immediate != want.immediate)
          report_field("immediate", w, want.immediate, got.immediate);
        if (out_tdata[63:57] != '0)
          report_field("padding", w, '0, 32'(out_tdata[63:57]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rv32im_instruction_decoder_top_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(480, 0, 0);
    test_random_phase(470, 47, 0);
    test_backpressure();
    test_random_phase(470, 0, 47);
    test_random_phase(470, 26, 26);
    in_tvalid <= 1'b0;
    set_idling(0, 0);
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rv32im_instruction_decoder_top_tb: clean");
    end else begin
      $display("rv32im_instruction_decoder_top_tb: errors");
    end
    $finish;
  end

endmodule
